### sv/ltsc_pkg.sv
// ----------------------------------------------------------------------------
// ltsc_pkg
// Types and constants shared by the texture slot cache: payload structs,
// status codes, the scan record passed along the cell chain and the slot
// write command.
// ----------------------------------------------------------------------------
package ltsc_pkg;

    localparam int NUM_SLOTS = 24;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KEY_W     = 16;
    localparam int STAMP_W   = 32;
    localparam int OUT_SLOT_W = 5;

    // result status codes
    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_HIT   = 2'd1,
        ST_FILL  = 2'd2,
        ST_EVICT = 2'd3
    } t_status;

    // input item
    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic             source_valid;
    } t_in_item;

    // result item
    typedef struct packed {
        t_status               status;
        logic [OUT_SLOT_W-1:0] slot;
    } t_out_item;

    // search record handed from cell to cell
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [SLOT_W-1:0]  hit_idx;
        logic               free;
        logic [SLOT_W-1:0]  free_idx;
        logic [STAMP_W-1:0] min_stamp;
        logic [SLOT_W-1:0]  victim_idx;
    } t_scan;

    // broadcast slot update
    typedef struct packed {
        logic               clear;
        logic               en;
        logic [SLOT_W-1:0]  idx;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_wr_cmd;

endpackage

### sv/ltsc_cell.sv
// ----------------------------------------------------------------------------
// ltsc_cell
// One cache slot: holds key, valid mark and stamp, folds its slot into the
// search record passing by and registers the record for the next cell.
// ----------------------------------------------------------------------------
module ltsc_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [ltsc_pkg::SLOT_W-1:0] i_idx,
    input  logic [ltsc_pkg::KEY_W-1:0]  i_key,
    input  ltsc_pkg::t_wr_cmd       i_wr,
    input  ltsc_pkg::t_scan         i_scan,
    output ltsc_pkg::t_scan         o_scan
);
    import ltsc_pkg::*;

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [STAMP_W-1:0] r_stamp;
    t_scan              r_scan;
    t_scan              n_scan;
    logic               match;
    logic               older;

    // fold this slot into the passing record
    always_comb begin
        match  = r_valid && (r_key == i_key);
        older  = r_stamp < i_scan.min_stamp;
        n_scan = i_scan;
        if (!i_scan.hit && match) begin
            n_scan.hit     = 1'b1;
            n_scan.hit_idx = i_idx;
        end
        if (!i_scan.free && !r_valid) begin
            n_scan.free     = 1'b1;
            n_scan.free_idx = i_idx;
        end
        if (older) begin
            n_scan.min_stamp  = r_stamp;
            n_scan.victim_idx = i_idx;
        end
    end

    // record stage toward the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.vld <= 1'b0;
        end else begin
            r_scan.vld <= i_scan.vld;
        end
        r_scan.hit        <= n_scan.hit;
        r_scan.hit_idx    <= n_scan.hit_idx;
        r_scan.free       <= n_scan.free;
        r_scan.free_idx   <= n_scan.free_idx;
        r_scan.min_stamp  <= n_scan.min_stamp;
        r_scan.victim_idx <= n_scan.victim_idx;
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            r_valid <= 1'b0;
            r_key   <= '0;
            r_stamp <= '0;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_valid <= 1'b1;
            r_key   <= i_wr.key;
            r_stamp <= i_wr.stamp;
        end
    end

    assign o_scan = r_scan;

endmodule

### sv/ltsc_ctrl.sv
// ----------------------------------------------------------------------------
// ltsc_ctrl
// Sequencer of the slot cache: takes an item, launches a search down the
// cell chain, picks hit, free slot or victim, updates the use clock and
// holds the result in an output register; a flush clears every slot instead.
// ----------------------------------------------------------------------------
module ltsc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ltsc_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ltsc_pkg::t_out_item  o_out_data,
    output logic [ltsc_pkg::KEY_W-1:0] o_key,
    output ltsc_pkg::t_scan      o_scan,
    input  ltsc_pkg::t_scan      i_scan,
    output ltsc_pkg::t_wr_cmd    o_wr
);
    import ltsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item;
    logic [STAMP_W-1:0] r_clock, n_clock;
    t_status            r_status, n_status;
    logic [SLOT_W-1:0]  r_pick, n_pick;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               lookup_ok;
    logic [STAMP_W-1:0] tick_val;
    logic [SLOT_W+OUT_SLOT_W-1:0] pick_ext;

    assign lookup_ok = !r_item.kind && (r_item.key != '0) && r_item.source_valid;
    assign tick_val  = (r_clock == '1) ? r_clock : r_clock + STAMP_W'(1);
    assign pick_ext  = {{OUT_SLOT_W{1'b0}}, r_pick};

    // sequencing, decision and slot update
    always_comb begin
        n_state  = r_state;
        n_clock  = r_clock;
        n_status = r_status;
        n_pick   = r_pick;
        o_scan            = '0;
        o_scan.min_stamp  = '1;
        o_wr     = '0;
        o_wr.key = r_item.key;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                n_status = ST_NONE;
                n_pick   = '0;
                if (r_item.kind) begin
                    o_wr.clear = 1'b1;
                    n_clock    = '0;
                    n_state    = S_DONE;
                end else if (lookup_ok) begin
                    o_scan.vld = 1'b1;
                    n_state    = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_scan.vld) begin
                    if (i_scan.hit) begin
                        n_status = ST_HIT;
                        n_pick   = i_scan.hit_idx;
                    end else if (i_scan.free) begin
                        n_status = ST_FILL;
                        n_pick   = i_scan.free_idx;
                    end else begin
                        n_status = ST_EVICT;
                        n_pick   = i_scan.victim_idx;
                    end
                    o_wr.en    = 1'b1;
                    o_wr.idx   = n_pick;
                    o_wr.stamp = tick_val;
                    n_clock    = tick_val;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and held item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clock <= '0;
        end else begin
            r_state <= n_state;
            r_clock <= n_clock;
        end
        if (r_state == S_IDLE && i_in_valid) r_item <= i_in_data;
        r_status <= n_status;
        r_pick   <= n_pick;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out.status <= r_status;
            r_out.slot   <= (r_status == ST_NONE) ? '0 : pick_ext[OUT_SLOT_W-1:0];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_key       = r_item.key;

endmodule

### sv/lru_texture_slot_cache.sv
// ----------------------------------------------------------------------------
// lru_texture_slot_cache
// Fully associative texture handle cache with timestamp based LRU
// replacement, built as a row of slot cells that a search record walks.
// ----------------------------------------------------------------------------
// an input transaction is taken in the idle state; the start state launches the
// search record, each slot cell registers it on its way along the chain, the scan
// state picks the slot and the done state loads the output register; a new input is
// taken only after that, and a flush or ignored lookup skips the search
// reset: synchronous active low, clears every slot, stamp and the use clock
module lru_texture_slot_cache (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ltsc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ltsc_pkg::t_out_item o_out_data
);
    import ltsc_pkg::*;

    t_scan            scan [NUM_SLOTS+1];
    t_wr_cmd          wr;
    logic [KEY_W-1:0] key;

    // sequencer
    ltsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_key       (key),
        .o_scan      (scan[0]),
        .i_scan      (scan[NUM_SLOTS]),
        .o_wr        (wr)
    );

    // chain of slot cells
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        ltsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_key   (key),
            .i_wr    (wr),
            .i_scan  (scan[g]),
            .o_scan  (scan[g+1])
        );
    end

endmodule

### tb/sv/ltsc_checker.sv
// ----------------------------------------------------------------------------
// ltsc_checker
// Watches both channels of the texture slot cache and predicts the result of
// every input transaction with its own copy of the slot table and use clock.
// Results are compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ltsc_checker
    import ltsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG_CAP = 50;

    // shadow slot table
    logic [KEY_W-1:0]   shadow_key[NUM_SLOTS];
    logic               shadow_used[NUM_SLOTS];
    logic [STAMP_W-1:0] shadow_stamp[NUM_SLOTS];
    logic [STAMP_W-1:0] lru_clock;

    t_out_item bind_results_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // empty every slot and restart the use clock
    function automatic void wipe_slots();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_key[i]   = '0;
            shadow_used[i]  = 1'b0;
            shadow_stamp[i] = '0;
        end
        lru_clock = '0;
    endfunction

    // next stamp, holding at the top value
    function automatic logic [STAMP_W-1:0] next_stamp();
        if (lru_clock != '1) begin
            lru_clock = lru_clock + 1'b1;
        end
        return lru_clock;
    endfunction

    // expected binding for one transaction, updating the shadow table
    function automatic t_out_item bind_texture(t_in_item item);
        t_out_item res;
        int        pick;
        int        victim;
        res.status = ST_NONE;
        res.slot   = '0;
        pick       = -1;
        victim     = 0;
        if (item.kind) begin
            wipe_slots();
        end else if (item.key != '0 && item.source_valid) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (shadow_used[i] && shadow_key[i] == item.key) begin
                    pick = i;
                    break;
                end
            end
            if (pick >= 0) begin
                shadow_stamp[pick] = next_stamp();
                res.status = ST_HIT;
            end else begin
                // lowest free slot, else oldest stamp with lowest index on ties
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!shadow_used[i]) begin
                        pick = i;
                        break;
                    end
                    if (shadow_stamp[i] < shadow_stamp[victim]) begin
                        victim = i;
                    end
                end
                if (pick >= 0) begin
                    res.status = ST_FILL;
                end else begin
                    pick = victim;
                    res.status = ST_EVICT;
                end
                shadow_key[pick]   = item.key;
                shadow_used[pick]  = 1'b1;
                shadow_stamp[pick] = next_stamp();
            end
            res.slot = OUT_SLOT_W'(pick);
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (o_fail_count < LOG_CAP) begin
            $display("%0t ltsc_checker: %s", $realtime, msg);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            wipe_slots();
            bind_results_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                bind_results_q.push_back(bind_texture(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (bind_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d slot %0d",
                                              i_out_data.status, i_out_data.slot));
                end else begin
                    want = bind_results_q.pop_front();
                    if (i_out_data.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out_data.status, want.status));
                    end
                    if (i_out_data.slot !== want.slot) begin
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  i_out_data.slot, want.slot));
                    end
                end
            end
        end
        o_pending <= bind_results_q.size();
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the texture slot cache: a short directed run over
// the special lookups and flushes, then random lookups drawn mostly from a
// small key pool so hits, fills and evictions all occur, under phases of
// sender idling and receiver stalls. The checker does all result checking.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ltsc_pkg::*;

    localparam logic KIND_LOOKUP  = 1'b0;
    localparam logic KIND_FLUSH   = 1'b1;
    localparam int   PHASES       = 4;
    localparam int   PHASE_ITEMS  = 375;
    localparam int   POOL_MAX     = 48;
    localparam int   STALL_LIMIT  = 3000;
    localparam int   TAIL_CYCLES  = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        idle_pct;
    int        stall_pct;
    int        quiet_cycles;

    logic [KEY_W-1:0] key_pool[POOL_MAX];

    lru_texture_slot_cache i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    ltsc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(logic kind, logic [KEY_W-1:0] key, logic src_ok);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid             <= 1'b1;
        in_data.kind         <= kind;
        in_data.key          <= key;
        in_data.source_valid <= src_ok;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // hold the sender off until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int idle_tbl[PHASES]  = '{0, 45, 0, 17};
        int stall_tbl[PHASES] = '{0, 0, 45, 17};
        int pool_tbl[PHASES]  = '{16, 28, 40, 24};
        int pool_size;
        int pick;
        quiet_cycles = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        out_ready    <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        i_rst_n      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored lookups, flush, fill, hit, extreme keys
        send_item(KIND_LOOKUP, 16'h0000, 1'b1);
        send_item(KIND_LOOKUP, 16'h1234, 1'b0);
        send_item(KIND_FLUSH,  16'h0000, 1'b0);
        send_item(KIND_LOOKUP, 16'hFFFF, 1'b1);
        send_item(KIND_LOOKUP, 16'hFFFF, 1'b1);
        send_item(KIND_LOOKUP, 16'h0001, 1'b1);
        send_item(KIND_LOOKUP, 16'h8000, 1'b1);
        send_item(KIND_LOOKUP, 16'h0001, 1'b1);
        send_item(KIND_LOOKUP, 16'h8000, 1'b0);
        send_item(KIND_FLUSH,  16'hFFFF, 1'b1);
        send_item(KIND_LOOKUP, 16'h8000, 1'b1);
        send_item(KIND_LOOKUP, 16'h0001, 1'b1);
        send_item(KIND_LOOKUP, 16'h0000, 1'b0);
        send_item(KIND_LOOKUP, 16'h5555, 1'b1);
        send_item(KIND_LOOKUP, 16'hAAAA, 1'b1);

        // random phases: mostly pool keys so the table fills and evicts
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = idle_tbl[ph];
            stall_pct = stall_tbl[ph];
            pool_size = pool_tbl[ph];
            for (int j = 0; j < pool_size; j++) begin
                key_pool[j] = KEY_W'($urandom_range(1, 65535));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 1) begin
                    send_item(KIND_FLUSH, KEY_W'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)));
                end else if (pick < 4) begin
                    send_item(KIND_LOOKUP, '0, 1'($urandom_range(0, 1)));
                end else if (pick < 8) begin
                    send_item(KIND_LOOKUP, KEY_W'($urandom_range(0, 65535)), 1'b0);
                end else if (pick < 14) begin
                    send_item(KIND_LOOKUP, KEY_W'($urandom_range(1, 65535)), 1'b1);
                end else begin
                    send_item(KIND_LOOKUP, key_pool[$urandom_range(0, pool_size - 1)],
                              1'b1);
                end
            end
            // sender waits for the cache to empty its result pipe
            if (ph == 0) begin
                drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
